// File: hw/rtl/klt_pkg.sv
// Shared widths, opcodes, chain link type and balance arithmetic for the ledger table.
`default_nettype none
package klt_pkg;

	localparam int OP_W  = 2;
	localparam int KEY_W = 64;
	localparam int AMT_W = 40;
	localparam int BAL_W = 48;
	localparam int EXT_W = BAL_W + 2;

	localparam logic [OP_W-1:0] OP_COINBASE = 2'd0;
	localparam logic [OP_W-1:0] OP_TRANSFER = 2'd1;
	localparam logic [OP_W-1:0] OP_TASK     = 2'd2;

	// Search results handed from one cell to the next.
	typedef struct packed {
		logic             s_hit;
		logic             r_hit;
		logic [BAL_W-1:0] s_bal;
		logic [BAL_W-1:0] r_bal;
	} link_t;

	function automatic logic [EXT_W-1:0] ext_bal(input logic [BAL_W-1:0] b);
		ext_bal = {{(EXT_W-BAL_W){b[BAL_W-1]}}, b};
	endfunction

	function automatic logic [EXT_W-1:0] ext_amt(input logic [AMT_W-1:0] a);
		ext_amt = {{(EXT_W-AMT_W){1'b0}}, a};
	endfunction

	// Clamp a widened sum back into the signed balance range.
	function automatic logic [BAL_W-1:0] sat_bal(input logic [EXT_W-1:0] v);
		logic [BAL_W-1:0] res;
		if ((v[EXT_W-1:BAL_W-1] == '0) || (v[EXT_W-1:BAL_W-1] == '1)) begin
			res = v[BAL_W-1:0];
		end else if (v[EXT_W-1]) begin
			res = {1'b1, {(BAL_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(BAL_W-1){1'b1}}};
		end
		sat_bal = res;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/klt_cell.sv
// One account slot of the ledger chain: stored key and balance, local match, link stage.
`default_nettype none
module klt_cell #(
	parameter int KEY_BITS = 64,
	parameter int IDX_W    = 6,
	parameter int CNT_W    = 7,
	parameter int INDEX    = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [CNT_W-1:0]     count,
	input  wire logic [KEY_BITS-1:0]  skey,
	input  wire logic [KEY_BITS-1:0]  rkey,
	input  wire klt_pkg::link_t       link_in,
	input  wire logic [IDX_W-1:0]     sidx_in,
	input  wire logic [IDX_W-1:0]     ridx_in,
	output klt_pkg::link_t            link_out,
	output logic      [IDX_W-1:0]     sidx_out,
	output logic      [IDX_W-1:0]     ridx_out,
	input  wire logic                 wr_s,
	input  wire logic                 wr_r,
	input  wire logic [IDX_W-1:0]     ws_idx,
	input  wire logic [IDX_W-1:0]     wr_idx,
	input  wire logic [klt_pkg::BAL_W-1:0] ws_bal,
	input  wire logic [klt_pkg::BAL_W-1:0] wr_bal
);
	import klt_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic [BAL_W-1:0]    bal_q;
	link_t               link_q;
	logic [IDX_W-1:0]    sidx_q;
	logic [IDX_W-1:0]    ridx_q;
	logic                occupied;
	logic                s_mine;
	logic                r_mine;

	assign occupied = CNT_W'(INDEX) < count;
	assign s_mine   = occupied && (key_q == skey);
	assign r_mine   = occupied && (key_q == rkey);

	// Keys are unique in the table, so at most one cell claims each lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q.s_hit <= 1'b0;
			link_q.r_hit <= 1'b0;
			link_q.s_bal <= '0;
			link_q.r_bal <= '0;
			sidx_q       <= '0;
			ridx_q       <= '0;
		end else begin
			link_q.s_hit <= link_in.s_hit | s_mine;
			link_q.r_hit <= link_in.r_hit | r_mine;
			link_q.s_bal <= s_mine ? bal_q : link_in.s_bal;
			link_q.r_bal <= r_mine ? bal_q : link_in.r_bal;
			sidx_q       <= s_mine ? IDX_W'(INDEX) : sidx_in;
			ridx_q       <= r_mine ? IDX_W'(INDEX) : ridx_in;
		end
	end

	// The receiver write wins when both land here: it carries the final balance.
	always_ff @(posedge clk) begin
		if (wr_r && (wr_idx == IDX_W'(INDEX))) begin
			key_q <= rkey;
			bal_q <= wr_bal;
		end else if (wr_s && (ws_idx == IDX_W'(INDEX))) begin
			key_q <= skey;
			bal_q <= ws_bal;
		end
	end

	assign link_out = link_q;
	assign sidx_out = sidx_q;
	assign ridx_out = ridx_q;

endmodule
`default_nettype wire

// File: hw/rtl/keyed_balance_ledger_table_unit.sv
// Top level of the account ledger table: transaction control and the chain of account cells.
//
// Usage: one transaction enters on the input channel (in_valid/in_ready) with opcode,
// sender_key, receiver_key and amount; exactly one result leaves on the output channel
// (out_valid/out_ready). A transfer on either side happens when valid and ready are high.
// Each account lives in one cell of a chain of ACCOUNTS cells. Every cell compares its key
// against the transaction in parallel, and the hit, index and balance ripple down the chain
// one cell per cycle while in the SEARCH state. The CALC state then computes the saturated
// debit and the ADD state the credit, and the APPLY state writes the cells and loads the
// result register. One transaction is in work at a time: the input is ready only in the idle
// state, so a new transaction is taken only once the previous one has been applied.
// The result register lets the next transaction start while a result waits; if the
// receiver still stalls when that next result is ready, the block holds it and the table
// writes until the output frees up.
// Reset empties the table (account count to zero) and drops any result in flight; no
// clearing pass is needed.
`default_nettype none
module keyed_balance_ledger_table_unit #(
	parameter int ACCOUNTS = 64,
	parameter int KEY_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [klt_pkg::OP_W-1:0]      opcode,
	input  wire logic [klt_pkg::KEY_W-1:0]     sender_key,
	input  wire logic [klt_pkg::KEY_W-1:0]     receiver_key,
	input  wire logic [klt_pkg::AMT_W-1:0]     amount,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               funds_ok,
	output logic signed [klt_pkg::BAL_W-1:0]   sender_balance,
	output logic signed [klt_pkg::BAL_W-1:0]   receiver_balance,
	output logic                               sender_not_stored,
	output logic                               receiver_not_stored
);
	import klt_pkg::*;

	localparam int IDX_W = (ACCOUNTS > 1) ? $clog2(ACCOUNTS) : 1;
	localparam int CNT_W = $clog2(ACCOUNTS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_CALC   = 3'd2;
	localparam logic [2:0] ST_ADD    = 3'd3;
	localparam logic [2:0] ST_APPLY  = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    step_q;
	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] skey_q;
	logic [KEY_BITS-1:0] rkey_q;
	logic [AMT_W-1:0]    amt_q;

	logic                funds_ok_q;
	logic                s_ns_q;
	logic                r_ns_q;
	logic                same_q;
	logic [IDX_W-1:0]    s_idx_q;
	logic [IDX_W-1:0]    r_idx_q;
	logic [BAL_W-1:0]    snew_q;
	logic [BAL_W-1:0]    rbase_q;
	logic [BAL_W-1:0]    rnew_q;

	logic                res_funds_ok_q;
	logic [BAL_W-1:0]    res_sbal_q;
	logic [BAL_W-1:0]    res_rbal_q;
	logic                res_s_ns_q;
	logic                res_r_ns_q;

	link_t               chain [ACCOUNTS+1];
	logic [IDX_W-1:0]    sidx_chain [ACCOUNTS+1];
	logic [IDX_W-1:0]    ridx_chain [ACCOUNTS+1];

	logic                in_take;
	logic                apply_go;
	logic                is_xfer;
	logic                is_cb;
	logic                is_task;
	logic                r_need;
	link_t               tail;
	logic [BAL_W-1:0]    s_prior;
	logic [BAL_W-1:0]    r_prior;
	logic                s_create;
	logic                s_full;
	logic                s_add;
	logic [CNT_W-1:0]    cnt1;
	logic                same;
	logic                r_create;
	logic                r_full;
	logic                r_add;
	logic [IDX_W-1:0]    s_idx_c;
	logic [IDX_W-1:0]    r_idx_c;
	logic                wr_s;
	logic                wr_r;

	assign in_ready = (state_q == ST_IDLE);
	assign in_take  = in_valid && in_ready;
	assign apply_go = (state_q == ST_APPLY) && (!out_valid_q || out_ready);

	assign is_xfer = (op_q == OP_TRANSFER);
	assign is_cb   = (op_q == OP_COINBASE);
	assign is_task = !is_xfer && !is_cb;
	assign r_need  = is_xfer || is_cb;

	// Chain of account cells.
	assign chain[0]      = '0;
	assign sidx_chain[0] = '0;
	assign ridx_chain[0] = '0;

	for (genvar i = 0; i < ACCOUNTS; i++) begin : g_cell
		klt_cell #(
			.KEY_BITS (KEY_BITS),
			.IDX_W    (IDX_W),
			.CNT_W    (CNT_W),
			.INDEX    (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.count    (count_q),
			.skey     (skey_q),
			.rkey     (rkey_q),
			.link_in  (chain[i]),
			.sidx_in  (sidx_chain[i]),
			.ridx_in  (ridx_chain[i]),
			.link_out (chain[i+1]),
			.sidx_out (sidx_chain[i+1]),
			.ridx_out (ridx_chain[i+1]),
			.wr_s     (wr_s),
			.wr_r     (wr_r),
			.ws_idx   (s_idx_q),
			.wr_idx   (r_idx_q),
			.ws_bal   (snew_q),
			.wr_bal   (rnew_q)
		);
	end

	// Lookup results at the end of the chain and the account creation decisions.
	assign tail     = chain[ACCOUNTS];
	assign s_prior  = tail.s_hit ? tail.s_bal : '0;
	assign r_prior  = tail.r_hit ? tail.r_bal : '0;
	assign s_create = is_xfer && !tail.s_hit;
	assign s_full   = s_create && (count_q == CNT_W'(ACCOUNTS));
	assign s_add    = s_create && !s_full;
	assign cnt1     = count_q + CNT_W'(s_add);
	assign same     = is_xfer && (skey_q == rkey_q);
	assign r_create = r_need && !tail.r_hit && !same;
	assign r_full   = r_create && (cnt1 == CNT_W'(ACCOUNTS));
	assign r_add    = r_create && !r_full;
	assign s_idx_c  = tail.s_hit ? sidx_chain[ACCOUNTS] : count_q[IDX_W-1:0];
	assign r_idx_c  = same ? s_idx_c :
			(tail.r_hit ? ridx_chain[ACCOUNTS] : cnt1[IDX_W-1:0]);

	assign wr_s = apply_go && is_xfer && !s_ns_q;
	assign wr_r = apply_go && r_need && !r_ns_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !apply_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SEARCH;
						step_q  <= '0;
					end
				end
				ST_SEARCH: begin
					step_q <= step_q + CNT_W'(1);
					if (step_q == CNT_W'(ACCOUNTS - 1)) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					count_q <= cnt1 + CNT_W'(r_add);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_go) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q   <= opcode;
			skey_q <= sender_key[KEY_BITS-1:0];
			rkey_q <= receiver_key[KEY_BITS-1:0];
			amt_q  <= amount;
		end
		if (state_q == ST_CALC) begin
			funds_ok_q <= !is_xfer || ($signed(ext_bal(s_prior)) >= $signed(ext_amt(amt_q)));
			s_ns_q     <= s_full;
			r_ns_q     <= same ? s_full : r_full;
			same_q     <= same;
			s_idx_q    <= s_idx_c;
			r_idx_q    <= r_idx_c;
			snew_q     <= sat_bal(ext_bal(s_prior) - ext_amt(amt_q));
			rbase_q    <= r_prior;
		end
		// With one account on both sides the credit applies to the debited balance.
		if (state_q == ST_ADD) begin
			rnew_q <= sat_bal(ext_bal(same_q ? snew_q : rbase_q) + ext_amt(amt_q));
		end
		if (apply_go) begin
			res_funds_ok_q <= funds_ok_q;
			res_sbal_q     <= (is_xfer && !s_ns_q) ? (same_q ? rnew_q : snew_q) : '0;
			res_rbal_q     <= is_task ? rbase_q : (r_ns_q ? '0 : rnew_q);
			res_s_ns_q     <= s_ns_q;
			res_r_ns_q     <= r_ns_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign funds_ok            = res_funds_ok_q;
	assign sender_balance      = res_sbal_q;
	assign receiver_balance    = res_rbal_q;
	assign sender_not_stored   = res_s_ns_q;
	assign receiver_not_stored = res_r_ns_q;

endmodule
`default_nettype wire

// File: hw/rtl/klt_checker.sv
// Port-level checks for the ledger table and the bind that attaches them.
`default_nettype none
module klt_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          funds_ok,
	input wire logic [klt_pkg::BAL_W-1:0]     sender_balance,
	input wire logic [klt_pkg::BAL_W-1:0]     receiver_balance,
	input wire logic                          sender_not_stored,
	input wire logic                          receiver_not_stored
);
	import klt_pkg::*;

	// An account that could not be stored reports a zero balance.
	a_sender_ns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sender_not_stored |-> sender_balance == '0)
		else $error("sender not stored but balance nonzero");

	a_receiver_ns_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && receiver_not_stored |-> receiver_balance == '0)
		else $error("receiver not stored but balance nonzero");

	// Only one transaction is in work, so the input closes right after a transfer.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !$rose(out_valid))
		else $error("input reopened or result appeared too early");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(funds_ok)
			&& $stable(sender_balance) && $stable(receiver_balance)
			&& $stable(sender_not_stored) && $stable(receiver_not_stored))
		else $error("stalled result changed");

endmodule

bind keyed_balance_ledger_table_unit klt_checker u_klt_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (in_valid),
	.in_ready            (in_ready),
	.out_valid           (out_valid),
	.out_ready           (out_ready),
	.funds_ok            (funds_ok),
	.sender_balance      (sender_balance),
	.receiver_balance    (receiver_balance),
	.sender_not_stored   (sender_not_stored),
	.receiver_not_stored (receiver_not_stored)
);
`default_nettype wire
